// ----- hw/rtl/dse_pkg.sv -----
// ============================================================================
// dse_pkg
// Shared types and constants for the automaton state equivalence search:
// request codes, configuration register indexes, field widths, the count
// bundle passed to the search sequencer, and the sequencer state encoding.
// ============================================================================
`default_nettype none

package dse_pkg;

  // Widths of the request and result fields.
  localparam int ACT_W   = 2;
  localparam int ST_W    = 3;
  localparam int SYM_W   = 3;
  localparam int CFG_D_W = 4;
  localparam int CFG_I_W = 1;

  // Width of state and symbol counts and loop counters (holds up to 31).
  localparam int CNT_W = 5;

  // Result cap per run and the width of the result counter.
  localparam int RESULT_CAP = 28;
  localparam int RES_W      = 5;

  // Request actions.
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD = 2'd0,
    ACT_MARK = 2'd1,
    ACT_RUN  = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [CFG_I_W-1:0] {
    REG_NUM_STATES  = 1'b0,
    REG_NUM_SYMBOLS = 1'b1
  } cfg_reg_t;

  // Effective counts after saturation.
  typedef struct packed {
    logic [CNT_W-1:0] states;
    logic [CNT_W-1:0] symbols;
  } counts_t;

  // Search sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ROW,
    S_ROW_WAIT,
    S_PAIR,
    S_TRD,
    S_TWAIT,
    S_DWAIT,
    S_WB,
    S_EROW,
    S_EWAIT,
    S_ESCAN,
    S_EFIN
  } search_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dse_trans_store.sv -----
// ============================================================================
// dse_trans_store
// Transition table memory. One write port for transition loads and two
// registered read ports that fetch the targets of a state pair on one symbol.
// ============================================================================
`default_nettype none

module dse_trans_store #(
  parameter int MAX_STATES  = 8,
  parameter int MAX_SYMBOLS = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   wr_state,
  input  wire logic [((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1)-1:0] wr_symbol,
  input  wire logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   wr_target,
  input  wire logic                                          rd_en,
  input  wire logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   rd_state_a,
  input  wire logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   rd_state_b,
  input  wire logic [((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1)-1:0] rd_symbol,
  output logic      [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   target_a,
  output logic      [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   target_b
);

  localparam int SW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int KW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int DEPTH = MAX_STATES * (1 << KW);

  logic [SW-1:0] table_mem [DEPTH];

  // A row per state, one entry per symbol slot.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[{wr_state, wr_symbol}] <= wr_target;
    end
  end

  // Both targets are read on the same symbol and registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      target_a <= table_mem[{rd_state_a, rd_symbol}];
      target_b <= table_mem[{rd_state_b, rd_symbol}];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dse_search.sv -----
// ============================================================================
// dse_search
// Table-filling sequencer. Holds the distinct-pair rows in a small memory,
// initializes them from the accepting marks, repeats passes over all pairs
// and symbols until a pass marks nothing, then streams the unmarked pairs
// through an output register.
// ============================================================================
`default_nettype none

module dse_search #(
  parameter int MAX_STATES  = 8,
  parameter int MAX_SYMBOLS = 8
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          start,
  input  wire dse_pkg::counts_t                              counts,
  input  wire logic [MAX_STATES-1:0]                         accepting,
  output logic                                               busy,
  output logic                                               tr_rd_en,
  output logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   tr_state_a,
  output logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0]   tr_state_b,
  output logic [((MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1)-1:0] tr_symbol,
  input  wire logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] tr_target_a,
  input  wire logic [((MAX_STATES > 1) ? $clog2(MAX_STATES) : 1)-1:0] tr_target_b,
  output logic                                               res_valid,
  input  wire logic                                          res_stall,
  output logic [dse_pkg::ST_W-1:0]                           res_first,
  output logic [dse_pkg::ST_W-1:0]                           res_second,
  output logic                                               res_found,
  output logic                                               res_last
);

  import dse_pkg::*;

  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int KW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  // Sequencer registers.
  search_state_t            state, state_next;
  logic [CNT_W-1:0]         idx_i, idx_i_next;
  logic [CNT_W-1:0]         idx_j, idx_j_next;
  logic [CNT_W-1:0]         idx_k, idx_k_next;
  logic                     changed, changed_next;
  logic [MAX_STATES-1:0]    row_buf, row_buf_next;
  logic                     have_pend, have_pend_next;
  logic [ST_W-1:0]          pend_a, pend_a_next;
  logic [ST_W-1:0]          pend_b, pend_b_next;
  logic [RES_W-1:0]         res_cnt, res_cnt_next;

  // Output register.
  logic                     out_v, out_v_next;
  logic [ST_W-1:0]          out_a, out_a_next;
  logic [ST_W-1:0]          out_b, out_b_next;
  logic                     out_f, out_f_next;
  logic                     out_l, out_l_next;

  // Pair row memory ports.
  logic                     pw_en;
  logic [SW-1:0]            pw_addr;
  logic [MAX_STATES-1:0]    pw_data;
  logic                     pr_en;
  logic [SW-1:0]            pr_addr;
  logic [MAX_STATES-1:0]    pr_data;
  logic [MAX_STATES-1:0]    pair_rows [MAX_STATES];

  logic                     slot_free;
  logic                     hit;
  logic [CNT_W-1:0]         n_st;
  logic [CNT_W-1:0]         m_sym;

  assign n_st      = counts.states;
  assign m_sym     = counts.symbols;
  assign slot_free = !out_v || !res_stall;

  // A symbol leads the pair to a pair already known distinct.
  assign hit = (CNT_W'(tr_target_a) < n_st) && (CNT_W'(tr_target_b) < n_st) &&
               pr_data[tr_target_b];

  // Pair row memory, one row of distinct bits per state.
  always_ff @(posedge clk) begin
    if (pw_en) begin
      pair_rows[pw_addr] <= pw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_en) begin
      pr_data <= pair_rows[pr_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      changed   <= 1'b0;
      have_pend <= 1'b0;
      res_cnt   <= '0;
      out_v     <= 1'b0;
    end else begin
      state     <= state_next;
      changed   <= changed_next;
      have_pend <= have_pend_next;
      res_cnt   <= res_cnt_next;
      out_v     <= out_v_next;
    end
  end

  // Loop counters and payload registers.
  always_ff @(posedge clk) begin
    idx_i   <= idx_i_next;
    idx_j   <= idx_j_next;
    idx_k   <= idx_k_next;
    row_buf <= row_buf_next;
    pend_a  <= pend_a_next;
    pend_b  <= pend_b_next;
    out_a   <= out_a_next;
    out_b   <= out_b_next;
    out_f   <= out_f_next;
    out_l   <= out_l_next;
  end

  // Next state and memory controls.
  always_comb begin
    state_next     = state;
    idx_i_next     = idx_i;
    idx_j_next     = idx_j;
    idx_k_next     = idx_k;
    changed_next   = changed;
    row_buf_next   = row_buf;
    have_pend_next = have_pend;
    pend_a_next    = pend_a;
    pend_b_next    = pend_b;
    res_cnt_next   = res_cnt;
    out_v_next     = out_v && res_stall;
    out_a_next     = out_a;
    out_b_next     = out_b;
    out_f_next     = out_f;
    out_l_next     = out_l;
    pw_en          = 1'b0;
    pw_addr        = idx_i[SW-1:0];
    pw_data        = row_buf;
    pr_en          = 1'b0;
    pr_addr        = idx_i[SW-1:0];
    tr_rd_en       = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          idx_i_next = '0;
          state_next = S_INIT;
        end
      end

      // Seed each row: a pair is distinct when exactly one state accepts.
      S_INIT: begin
        if (idx_i >= n_st) begin
          idx_i_next   = '0;
          changed_next = 1'b0;
          state_next   = S_ROW;
        end else begin
          pw_en      = 1'b1;
          pw_data    = accepting ^ {MAX_STATES{accepting[idx_i[SW-1:0]]}};
          idx_i_next = idx_i + CNT_W'(1);
        end
      end

      // Start a row, or close the pass when all rows are done.
      S_ROW: begin
        if (idx_i >= n_st) begin
          idx_i_next = '0;
          if (changed) begin
            changed_next = 1'b0;
            state_next   = S_ROW;
          end else begin
            res_cnt_next   = '0;
            have_pend_next = 1'b0;
            state_next     = S_EROW;
          end
        end else begin
          pr_en      = 1'b1;
          state_next = S_ROW_WAIT;
        end
      end

      S_ROW_WAIT: begin
        row_buf_next = pr_data;
        idx_j_next   = '0;
        state_next   = S_PAIR;
      end

      // Pick the next unmarked pair of the row.
      S_PAIR: begin
        if (idx_j >= n_st) begin
          state_next = S_WB;
        end else if (row_buf[idx_j[SW-1:0]] || (m_sym == '0)) begin
          idx_j_next = idx_j + CNT_W'(1);
        end else begin
          idx_k_next = '0;
          state_next = S_TRD;
        end
      end

      // Fetch both targets on the current symbol.
      S_TRD: begin
        tr_rd_en   = 1'b1;
        state_next = S_TWAIT;
      end

      // Fetch the row of the first target.
      S_TWAIT: begin
        pr_en      = 1'b1;
        pr_addr    = tr_target_a;
        state_next = S_DWAIT;
      end

      // Test the target pair and step the symbol.
      S_DWAIT: begin
        if (hit) begin
          row_buf_next[idx_j[SW-1:0]] = 1'b1;
          changed_next = 1'b1;
          idx_j_next   = idx_j + CNT_W'(1);
          state_next   = S_PAIR;
        end else if ((idx_k + CNT_W'(1)) >= m_sym) begin
          idx_j_next = idx_j + CNT_W'(1);
          state_next = S_PAIR;
        end else begin
          idx_k_next = idx_k + CNT_W'(1);
          state_next = S_TRD;
        end
      end

      // Write the row back and move on.
      S_WB: begin
        pw_en      = 1'b1;
        idx_i_next = idx_i + CNT_W'(1);
        state_next = S_ROW;
      end

      // Report: load each row in turn.
      S_EROW: begin
        if (idx_i >= n_st) begin
          state_next = S_EFIN;
        end else begin
          pr_en      = 1'b1;
          state_next = S_EWAIT;
        end
      end

      S_EWAIT: begin
        row_buf_next = pr_data;
        idx_j_next   = idx_i + CNT_W'(1);
        state_next   = S_ESCAN;
      end

      // Scan the upper half of the row; one pair is held back so the last
      // one can be flagged.
      S_ESCAN: begin
        if (idx_j >= n_st) begin
          idx_i_next = idx_i + CNT_W'(1);
          state_next = S_EROW;
        end else if (row_buf[idx_j[SW-1:0]]) begin
          idx_j_next = idx_j + CNT_W'(1);
        end else if (!have_pend || slot_free) begin
          if (have_pend) begin
            out_v_next = 1'b1;
            out_a_next = pend_a;
            out_b_next = pend_b;
            out_f_next = 1'b1;
            out_l_next = 1'b0;
          end
          have_pend_next = 1'b1;
          pend_a_next    = idx_i[ST_W-1:0];
          pend_b_next    = idx_j[ST_W-1:0];
          res_cnt_next   = res_cnt + RES_W'(1);
          idx_j_next     = idx_j + CNT_W'(1);
          if ((res_cnt + RES_W'(1)) == RES_W'(RESULT_CAP)) begin
            state_next = S_EFIN;
          end
        end
      end

      // Send the held pair as the last request, or the empty report.
      S_EFIN: begin
        if (slot_free) begin
          out_v_next     = 1'b1;
          out_a_next     = have_pend ? pend_a : '0;
          out_b_next     = have_pend ? pend_b : '0;
          out_f_next     = have_pend;
          out_l_next     = 1'b1;
          have_pend_next = 1'b0;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign tr_state_a = idx_i[SW-1:0];
  assign tr_state_b = idx_j[SW-1:0];
  assign tr_symbol  = idx_k[KW-1:0];
  assign res_valid  = out_v;
  assign res_first  = out_a;
  assign res_second = out_b;
  assign res_found  = out_f;
  assign res_last   = out_l;

endmodule

`default_nettype wire

// ----- hw/rtl/dfa_state_equivalence.sv -----
// ============================================================================
// dfa_state_equivalence
// Finds equivalent states of a deterministic automaton by table filling.
// ============================================================================
// Requests load one transition, mark one state accepting, or start a search.
// Loads and marks give no result. A search first seeds the pair table, one
// row per state (n = effective state count), then repeats passes until one
// marks nothing; each symbol check of a pair goes through the transition
// memory and then the pair-row memory, one at a time, and at most
// n*(n-1)/2 + 1 passes run. Reporting waits on any output stall. The block
// accepts no request while a search is running; configuration writes are
// always taken. Equivalent pairs come out in row-major order, at most 28,
// the final one flagged last; a search with none sends one request with
// found low.
// ============================================================================
`default_nettype none

module dfa_state_equivalence #(
  parameter int MAX_STATES  = 8,
  parameter int MAX_SYMBOLS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Request channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dse_pkg::ACT_W-1:0]     action,
  input  wire logic [dse_pkg::ST_W-1:0]      src_state,
  input  wire logic [dse_pkg::SYM_W-1:0]     symbol,
  input  wire logic [dse_pkg::ST_W-1:0]      dest_state,
  // Result channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dse_pkg::ST_W-1:0]           first_state,
  output logic [dse_pkg::ST_W-1:0]           second_state,
  output logic                               found,
  output logic                               last,
  // Configuration write channel.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dse_pkg::CFG_I_W-1:0]   cfg_index,
  input  wire logic [dse_pkg::CFG_D_W-1:0]   cfg_data
);

  import dse_pkg::*;

  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int KW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [CFG_D_W-1:0]    num_states;
  logic [CFG_D_W-1:0]    num_symbols;
  logic [MAX_STATES-1:0] accepting;
  counts_t               counts;
  logic                  req_take;
  logic                  load_ok;
  logic                  mark_ok;
  logic                  run_go;
  logic                  busy;
  logic                  tr_rd_en;
  logic [SW-1:0]         tr_state_a;
  logic [SW-1:0]         tr_state_b;
  logic [KW-1:0]         tr_symbol;
  logic [SW-1:0]         tr_target_a;
  logic [SW-1:0]         tr_target_b;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states  <= CFG_D_W'(8);
      num_symbols <= CFG_D_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_STATES:  num_states  <= cfg_data;
        REG_NUM_SYMBOLS: num_symbols <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Counts saturate at the sizes built in.
  always_comb begin
    counts.states  = (CNT_W'(num_states) > CNT_W'(MAX_STATES)) ?
                     CNT_W'(MAX_STATES) : CNT_W'(num_states);
    counts.symbols = (CNT_W'(num_symbols) > CNT_W'(MAX_SYMBOLS)) ?
                     CNT_W'(MAX_SYMBOLS) : CNT_W'(num_symbols);
  end

  // Request decode; indices outside the counts are dropped.
  assign in_stall = busy;
  assign req_take = in_valid && !in_stall;
  assign load_ok  = req_take && (action == ACT_LOAD) &&
                    (CNT_W'(src_state) < counts.states) &&
                    (CNT_W'(symbol) < counts.symbols) &&
                    (CNT_W'(dest_state) < counts.states);
  assign mark_ok  = req_take && (action == ACT_MARK) &&
                    (CNT_W'(src_state) < counts.states);
  assign run_go   = req_take && (action == ACT_RUN);

  // Accepting marks.
  always_ff @(posedge clk) begin
    if (rst) begin
      accepting <= '0;
    end else if (mark_ok) begin
      accepting[SW'(src_state)] <= 1'b1;
    end
  end

  dse_trans_store #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_trans (
    .clk        (clk),
    .wr_en      (load_ok),
    .wr_state   (SW'(src_state)),
    .wr_symbol  (KW'(symbol)),
    .wr_target  (SW'(dest_state)),
    .rd_en      (tr_rd_en),
    .rd_state_a (tr_state_a),
    .rd_state_b (tr_state_b),
    .rd_symbol  (tr_symbol),
    .target_a   (tr_target_a),
    .target_b   (tr_target_b)
  );

  dse_search #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (run_go),
    .counts      (counts),
    .accepting   (accepting),
    .busy        (busy),
    .tr_rd_en    (tr_rd_en),
    .tr_state_a  (tr_state_a),
    .tr_state_b  (tr_state_b),
    .tr_symbol   (tr_symbol),
    .tr_target_a (tr_target_a),
    .tr_target_b (tr_target_b),
    .res_valid   (out_valid),
    .res_stall   (out_stall),
    .res_first   (first_state),
    .res_second  (second_state),
    .res_found   (found),
    .res_last    (last)
  );

endmodule

`default_nettype wire

// ----- bench/dse_checker.sv -----
// ============================================================================
// dse_checker
// Watches the request, result and configuration channels of the automaton
// state equivalence block. It keeps its own transition table, accepting set
// and counts, works out the equivalent pairs of every accepted search, and
// compares each accepted result with the oldest expected pair.
// ============================================================================
module dse_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [dse_pkg::ACT_W-1:0]   action,
  input  logic [dse_pkg::ST_W-1:0]    src_state,
  input  logic [dse_pkg::SYM_W-1:0]   symbol,
  input  logic [dse_pkg::ST_W-1:0]    dest_state,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [dse_pkg::ST_W-1:0]    first_state,
  input  logic [dse_pkg::ST_W-1:0]    second_state,
  input  logic                        found,
  input  logic                        last,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [dse_pkg::CFG_I_W-1:0] cfg_index,
  input  logic [dse_pkg::CFG_D_W-1:0] cfg_data,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import dse_pkg::*;

  localparam int NUM_ST  = 8;
  localparam int NUM_SYM = 8;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ST_W-1:0] lo;
    logic [ST_W-1:0] hi;
    logic            found;
    logic            last;
  } pair_res_t;

  // Shadow copy of the automaton and the configuration.
  logic [ST_W-1:0]    next_state [NUM_ST][NUM_SYM];
  logic [NUM_ST-1:0]  accepting;
  logic [CFG_D_W-1:0] states_reg;
  logic [CFG_D_W-1:0] symbols_reg;

  pair_res_t equiv_pairs_q[$];
  pair_res_t exp_r;

  function automatic int live_states();
    return (states_reg > NUM_ST) ? NUM_ST : int'(states_reg);
  endfunction

  function automatic int live_symbols();
    return (symbols_reg > NUM_SYM) ? NUM_SYM : int'(symbols_reg);
  endfunction

  // Table filling: seed with the accepting split, then propagate through the
  // transitions until a pass marks nothing. A target at or above the live
  // state count never counts as distinct.
  function automatic void search_equivalent_pairs();
    logic [NUM_ST-1:0] distinct_rows [NUM_ST];
    int n;
    int m;
    int total;
    int cnt;
    bit changed;
    bit hit;
    logic [ST_W-1:0] ti;
    logic [ST_W-1:0] tj;
    n = live_states();
    m = live_symbols();
    for (int i = 0; i < NUM_ST; i++) distinct_rows[i] = '0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        distinct_rows[i][j] = accepting[i] ^ accepting[j];
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          if (!distinct_rows[i][j]) begin
            hit = 1'b0;
            for (int k = 0; k < m && !hit; k++) begin
              ti = next_state[i][k];
              tj = next_state[j][k];
              if (ti < n && tj < n && distinct_rows[ti][tj]) begin
                distinct_rows[i][j] = 1'b1;
                changed = 1'b1;
                hit = 1'b1;
              end
            end
          end
        end
      end
    end
    // Report unmarked pairs in row-major order, capped.
    total = 0;
    for (int i = 0; i < n; i++)
      for (int j = i + 1; j < n; j++)
        if (!distinct_rows[i][j] && total < RESULT_CAP) total++;
    if (total == 0) begin
      equiv_pairs_q.push_back('{lo: '0, hi: '0, found: 1'b0, last: 1'b1});
    end else begin
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (!distinct_rows[i][j] && cnt < total) begin
            cnt++;
            equiv_pairs_q.push_back('{lo: ST_W'(i), hi: ST_W'(j), found: 1'b1,
                                      last: (cnt == total)});
          end
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_ST; i++)
        for (int k = 0; k < NUM_SYM; k++)
          next_state[i][k] = '0;
      accepting = '0;
      states_reg = 4'd8;
      symbols_reg = 4'd2;
      equiv_pairs_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      // Results first, so a request taken in the same cycle queues behind.
      if (out_valid && !out_stall) begin
        if (equiv_pairs_q.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("unexpected result: first=%0d second=%0d found=%0b last=%0b",
                     first_state, second_state, found, last);
          errors++;
        end else begin
          exp_r = equiv_pairs_q.pop_front();
          if (exp_r.lo !== first_state || exp_r.hi !== second_state ||
              exp_r.found !== found || exp_r.last !== last) begin
            if (errors < REPORT_LIMIT)
              $display("result mismatch: expected %0d,%0d found=%0b last=%0b; got %0d,%0d found=%0b last=%0b",
                       exp_r.lo, exp_r.hi, exp_r.found, exp_r.last,
                       first_state, second_state, found, last);
            errors++;
          end
        end
      end

      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_STATES:  states_reg = cfg_data;
          REG_NUM_SYMBOLS: symbols_reg = cfg_data;
          default: ;
        endcase
      end

      // Requests: loads and marks only touch the shadow state.
      if (in_valid && !in_stall) begin
        case (action)
          ACT_LOAD: begin
            if (src_state < live_states() && symbol < live_symbols() &&
                dest_state < live_states())
              next_state[src_state][symbol] = dest_state;
          end
          ACT_MARK: begin
            if (src_state < live_states()) accepting[src_state] = 1'b1;
          end
          ACT_RUN: search_equivalent_pairs();
          default: ;
        endcase
      end

      pending <= equiv_pairs_q.size();
    end
  end

endmodule

// ----- bench/dfa_state_equivalence_tb.sv -----
// ============================================================================
// dfa_state_equivalence_tb
// Drives loads, accepting marks and searches into the state equivalence
// block under random gaps and output stalls, with a directed opening and
// random phases over many state and symbol counts; a checker beside the
// block predicts and compares every result.
// ============================================================================
module dfa_state_equivalence_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dse_pkg::*;

  localparam int NUM_ST        = 8;
  localparam int NUM_SYM       = 8;
  localparam int RANDOM_ITEMS  = 140;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 300;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [ACT_W-1:0]   action;
  logic [ST_W-1:0]    src_state;
  logic [SYM_W-1:0]   symbol;
  logic [ST_W-1:0]    dest_state;
  logic               out_valid;
  logic               out_stall;
  logic [ST_W-1:0]    first_state;
  logic [ST_W-1:0]    second_state;
  logic               found;
  logic               last;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_I_W-1:0] cfg_index;
  logic [CFG_D_W-1:0] cfg_data;
  int                 errors;
  int                 pending;

  // Stimulus bookkeeping: live counts and which table entries hold a target.
  int n_eff;
  int m_eff;
  bit written [NUM_ST][NUM_SYM];
  int useful_cnt;
  bit quiet;
  int hold_asks;
  int hold_served;

  dfa_state_equivalence dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .src_state(src_state), .symbol(symbol), .dest_state(dest_state),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_state(first_state), .second_state(second_state), .found(found), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dse_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .src_state(src_state), .symbol(symbol), .dest_state(dest_state),
    .out_valid(out_valid), .out_stall(out_stall),
    .first_state(first_state), .second_state(second_state), .found(found), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one request after a random gap and hold it until it is taken.
  // Valid is lowered only when a gap follows, never in the step it rises.
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [ST_W-1:0] src,
                          input logic [SYM_W-1:0] sym, input logic [ST_W-1:0] dst);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    src_state  <= src;
    symbol     <= sym;
    dest_state <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (act)
      ACT_LOAD: begin
        if (src < n_eff && sym < m_eff && dst < n_eff) begin
          written[src][sym] = 1'b1;
          useful_cnt++;
        end
      end
      ACT_MARK: if (src < n_eff) useful_cnt++;
      ACT_RUN:  useful_cnt++;
      default: ;
    endcase
  endtask

  // Wait until every expected result is in and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both count registers back to back; valid stays up between them.
  task automatic set_counts(input logic [CFG_D_W-1:0] ns, input logic [CFG_D_W-1:0] ms);
    cfg_valid <= 1'b1;
    cfg_index <= REG_NUM_STATES;
    cfg_data  <= ns;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_NUM_SYMBOLS;
    cfg_data  <= ms;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_eff = (ns > NUM_ST) ? NUM_ST : int'(ns);
    m_eff = (ms > NUM_SYM) ? NUM_SYM : int'(ms);
  endtask

  // Load every live table entry that has never been given a target, so a
  // search never reads an unwritten entry.
  task automatic fill_table();
    for (int s = 0; s < n_eff; s++)
      for (int k = 0; k < m_eff; k++)
        if (!written[s][k])
          send_req(ACT_LOAD, ST_W'(s), SYM_W'(k), ST_W'($urandom_range(0, n_eff - 1)));
  endtask

  // One random request: mostly live loads, some noise, rare marks.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && n_eff > 0 && m_eff > 0)
      send_req(ACT_LOAD, ST_W'($urandom_range(0, n_eff - 1)),
               SYM_W'($urandom_range(0, m_eff - 1)), ST_W'($urandom_range(0, n_eff - 1)));
    else if (r < 85)
      send_req(ACT_LOAD, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
    else if (r < 89)
      send_req(ACT_MARK, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
    else
      send_req(ACT_UNUSED, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
  endtask

  function automatic logic [CFG_D_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd15;
      3:       return 4'd8;
      4:       return CFG_D_W'($urandom_range(9, 15));
      default: return CFG_D_W'($urandom_range(2, 7));
    endcase
  endfunction

  // Result side: random stalls, quiet stretches, and one long hold-off on
  // request from the stimulus, started once results begin to come out.
  initial begin
    out_stall <= 1'b0;
    hold_served = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served && out_valid) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
        out_stall <= 1'b0;
      end else if (quiet || $urandom_range(0, 99) < 65) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
        else repeat ($urandom_range(0, 2)) @(posedge clk);
      end
    end
  end

  // Request side and verdict.
  initial begin
    int phase;
    int runs;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    action     <= ACT_LOAD;
    src_state  <= '0;
    symbol     <= '0;
    dest_state <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_NUM_STATES;
    cfg_data   <= '0;
    quiet = 1'b0;
    hold_asks = 0;
    useful_cnt = 0;
    n_eff = NUM_ST;
    m_eff = 2;
    for (int s = 0; s < NUM_ST; s++)
      for (int k = 0; k < NUM_SYM; k++)
        written[s][k] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Saturated state count with no symbols and nothing accepting: every
    // pair is equivalent, all 28 come out with last on the final one.
    set_counts(4'd15, 4'd0);
    send_req(ACT_LOAD, 3'd7, 3'd7, 3'd7);
    send_req(ACT_UNUSED, 3'd5, 3'd2, 3'd6);
    send_req(ACT_RUN, 3'd0, 3'd0, 3'd0);
    settle();

    // Empty automaton: loads and marks are dropped, the search reports none.
    set_counts(4'd0, 4'd1);
    send_req(ACT_MARK, 3'd3, 3'd0, 3'd0);
    send_req(ACT_LOAD, 3'd0, 3'd0, 3'd0);
    send_req(ACT_RUN, 3'd7, 3'd7, 3'd7);
    settle();

    // A single state has no pairs at all.
    set_counts(4'd1, 4'd1);
    send_req(ACT_LOAD, 3'd0, 3'd0, 3'd0);
    send_req(ACT_RUN, 3'd0, 3'd0, 3'd0);
    settle();

    // Two states split by acceptance: no equivalent pair.
    set_counts(4'd2, 4'd1);
    send_req(ACT_MARK, 3'd1, 3'd0, 3'd0);
    send_req(ACT_LOAD, 3'd1, 3'd0, 3'd0);
    send_req(ACT_RUN, 3'd0, 3'd0, 3'd0);
    settle();

    // All eight states on one symbol; a symbol past the count is dropped.
    set_counts(4'd15, 4'd1);
    send_req(ACT_LOAD, 3'd7, 3'd0, 3'd7);
    fill_table();
    send_req(ACT_LOAD, 3'd3, 3'd7, 3'd2);
    send_req(ACT_LOAD, 3'd0, 3'd0, 3'd7);
    send_req(ACT_RUN, 3'd0, 3'd0, 3'd0);
    settle();

    // Lowered state count leaves state 0 pointing past it.
    set_counts(4'd4, 4'd1);
    send_req(ACT_RUN, 3'd0, 3'd0, 3'd0);
    settle();

    // No symbols: only the accepting split decides.
    set_counts(4'd3, 4'd0);
    send_req(ACT_RUN, 3'd0, 3'd0, 3'd0);

    // Random phases: new counts, random traffic, fill, then one or two searches.
    useful_cnt = 0;
    phase = 0;
    while (useful_cnt < RANDOM_ITEMS) begin
      settle();
      quiet = ($urandom_range(0, 4) == 0);
      if (phase == 0) begin
        set_counts(4'd8, 4'd15);
      end else if (phase == 2) begin
        quiet = 1'b1;
        set_counts(CFG_D_W'($urandom_range(5, 8)), CFG_D_W'($urandom_range(2, 4)));
      end else begin
        set_counts(pick_count(), pick_count());
      end
      runs = ($urandom_range(0, 3) == 0) ? 2 : 1;
      for (int r = 0; r < runs; r++) begin
        repeat ($urandom_range(2, 10)) random_item();
        fill_table();
        // Hold the result side off while requests keep coming.
        if (phase == 2 && r == 0) hold_asks++;
        send_req(ACT_RUN, ST_W'($urandom), SYM_W'($urandom), ST_W'($urandom));
        if (phase == 2 && r == 0) repeat (4) random_item();
      end
      phase++;
    end
    settle();

    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
